// ===== design/hrde_pkg.sv =====
// Shared types and constants for the HID report differencer.
// Used by hrde_front, hrde_queue, hrde_back and hid_report_diff_to_events.
package hrde_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_MOUSE = 2'd0,
    OP_KBD   = 2'd1,
    OP_TICK  = 2'd2,
    OP_CONN  = 2'd3
  } op_e;

  // Event kinds on the output
  typedef enum logic [2:0] {
    EV_KEY_PRESS   = 3'd0,
    EV_KEY_RELEASE = 3'd1,
    EV_BTN_PRESS   = 3'd2,
    EV_BTN_RELEASE = 3'd3,
    EV_MOVE        = 3'd4,
    EV_SCROLL      = 3'd5,
    EV_TICK        = 3'd6
  } kind_e;

  localparam int unsigned NUM_SLOTS    = 6;
  localparam int unsigned NUM_KEYS     = 2 * NUM_SLOTS;
  // Pending-event bits: 8 modifier changes, 6 releases, 6 presses
  localparam int unsigned JOB_W        = 8 + 2 * NUM_SLOTS;
  localparam int unsigned IDX_W        = $clog2(JOB_W);
  localparam int unsigned KIDX_W       = $clog2(NUM_KEYS);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [7:0]  MOD_KEY_BASE = 8'hE0;

  // Mouse job bit positions
  localparam logic [IDX_W-1:0] MOUSE_MOVE_BIT   = 5'd0;
  localparam logic [IDX_W-1:0] MOUSE_SCROLL_BIT = 5'd1;
  localparam logic [IDX_W-1:0] MOUSE_BTN_BASE   = 5'd2;
  // Keyboard job: first slot-key position
  localparam logic [IDX_W-1:0] KBD_KEY_BASE     = 5'd8;

  typedef logic [IDX_W-1:0] idx_t;

  // One classified item: snapshot of the values plus the set of events to emit.
  // keys[0..5] hold the previous report's slots, keys[6..11] the new ones.
  typedef struct packed {
    op_e                        op;
    logic [63:0]                stamp;
    logic [7:0]                 flags;
    logic [NUM_KEYS-1:0][7:0]   keys;
    logic [7:0]                 dx;
    logic [7:0]                 dy;
    logic [7:0]                 wheel;
    logic [JOB_W-1:0]           mask;
  } job_t;

endpackage

// ===== design/hrde_front.sv =====
// Front end: accepts items, diffs them against the stored reports and builds jobs.
// Depends on hrde_pkg.
module hrde_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic                                full_i,
  input  hrde_pkg::op_e                       op_i,
  input  logic [63:0]                         stamp_i,
  input  logic [7:0]                          flags_i,
  input  logic [hrde_pkg::NUM_SLOTS-1:0][7:0] keys_i,
  input  logic [7:0]                          dx_i,
  input  logic [7:0]                          dy_i,
  input  logic [7:0]                          wheel_i,
  output logic                                stall_o,
  output logic                                push_o,
  output hrde_pkg::job_t                      job_o
);

  logic [7:0]                          prev_mod_q, prev_mod_d;
  logic [7:0]                          prev_btn_q, prev_btn_d;
  logic [hrde_pkg::NUM_SLOTS-1:0][7:0] prev_keys_q, prev_keys_d;
  logic [hrde_pkg::NUM_SLOTS-1:0]      rel, press;
  logic [hrde_pkg::JOB_W-1:0]          mask;
  logic                                accept;

  assign stall_o = full_i;
  assign accept  = valid_i && !full_i;

  // Find released and newly pressed keys, slot by slot
  always_comb begin
    for (int i = 0; i < hrde_pkg::NUM_SLOTS; i++) begin
      rel[i]   = (prev_keys_q[i] != 8'd0);
      press[i] = (keys_i[i] != 8'd0);
      for (int j = 0; j < hrde_pkg::NUM_SLOTS; j++) begin
        if (keys_i[j] == prev_keys_q[i]) rel[i] = 1'b0;
        if (prev_keys_q[j] == keys_i[i]) press[i] = 1'b0;
      end
    end
  end

  // Classify the item into a set of pending events
  always_comb begin
    unique case (op_i)
      hrde_pkg::OP_MOUSE: begin
        mask = {10'd0, flags_i ^ prev_btn_q, (wheel_i != 8'd0),
                ((dx_i != 8'd0) || (dy_i != 8'd0))};
      end
      hrde_pkg::OP_KBD: begin
        mask = {press, rel, flags_i ^ prev_mod_q};
      end
      hrde_pkg::OP_TICK: begin
        mask = hrde_pkg::JOB_W'(1);
      end
      default: begin
        mask = '0;
      end
    endcase
  end

  // Build the job and push only when it carries events
  always_comb begin
    job_o.op    = op_i;
    job_o.stamp = stamp_i;
    job_o.flags = flags_i;
    job_o.keys  = {keys_i, prev_keys_q};
    job_o.dx    = dx_i;
    job_o.dy    = dy_i;
    job_o.wheel = wheel_i;
    job_o.mask  = mask;
    push_o      = accept && (mask != '0);
  end

  // Update the stored reports on each transfer
  always_comb begin
    prev_mod_d  = prev_mod_q;
    prev_btn_d  = prev_btn_q;
    prev_keys_d = prev_keys_q;
    if (accept) begin
      unique case (op_i)
        hrde_pkg::OP_MOUSE: begin
          prev_btn_d = flags_i;
        end
        hrde_pkg::OP_KBD: begin
          prev_mod_d  = flags_i;
          prev_keys_d = keys_i;
        end
        hrde_pkg::OP_CONN: begin
          prev_mod_d  = '0;
          prev_btn_d  = '0;
          prev_keys_d = '0;
        end
        default: begin
          prev_mod_d = prev_mod_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mod_q  <= '0;
      prev_btn_q  <= '0;
      prev_keys_q <= '0;
    end else begin
      prev_mod_q  <= prev_mod_d;
      prev_btn_q  <= prev_btn_d;
      prev_keys_q <= prev_keys_d;
    end
  end

endmodule

// ===== design/hrde_queue.sv =====
// Short job queue between the front end and the event sequencer.
// Depends on hrde_pkg.
module hrde_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrde_pkg::job_t wdata_i,
  input  logic           pop_i,
  output hrde_pkg::job_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  hrde_pkg::job_t                     store_q [hrde_pkg::QUEUE_DEPTH];
  logic [hrde_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [hrde_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [hrde_pkg::QCNT_W-1:0]        count_q, count_d;

  assign full_o  = (count_q == hrde_pkg::QCNT_W'(hrde_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = store_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hrde_pkg::QPTR_W'(hrde_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hrde_pkg::QPTR_W'(hrde_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_ptr_q] <= wdata_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hrde_pkg::QCNT_W'(hrde_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from an empty queue");

endmodule

// ===== design/hrde_back.sv =====
// Event sequencer: walks a job's pending events lowest first, one per cycle while
// the output is not stalled, into the output register. Depends on hrde_pkg.
module hrde_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  hrde_pkg::job_t job_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [2:0]     event_kind_o,
  output logic [63:0]    event_time_o,
  output logic [7:0]     code_o,
  output logic [7:0]     dx_o,
  output logic [7:0]     dy_o,
  output logic [7:0]     scroll_o,
  output logic           last_o
);

  hrde_pkg::job_t             job_q, job_d;
  logic [hrde_pkg::JOB_W-1:0] mask_q, mask_d, mask_rest;
  logic                       work_valid_q, work_valid_d;
  hrde_pkg::idx_t             idx;
  hrde_pkg::idx_t             btn_idx;
  logic [2:0]                 bit_sel;
  logic [hrde_pkg::KIDX_W-1:0] key_idx;
  logic                       emit, fin;

  logic                       out_valid_q, out_valid_d;
  hrde_pkg::kind_e            kind_q, kind_d;
  logic [63:0]                time_q;
  logic [7:0]                 code_q, code_d;
  logic [7:0]                 dx_q, dx_d, dy_q, dy_d, scroll_q, scroll_d;
  logic                       last_q;

  // Pick the lowest pending event
  always_comb begin
    idx = '0;
    for (int i = hrde_pkg::JOB_W - 1; i >= 0; i--) begin
      if (mask_q[i]) idx = hrde_pkg::idx_t'(i);
    end
  end

  assign mask_rest = mask_q & (mask_q - 1'b1);
  assign emit      = work_valid_q && (!out_valid_q || !out_stall_i);
  assign fin       = (mask_rest == '0);
  assign pop_o     = !empty_i && (!work_valid_q || (emit && fin));

  // Decode the chosen event
  always_comb begin
    btn_idx  = idx - hrde_pkg::MOUSE_BTN_BASE;
    key_idx  = hrde_pkg::KIDX_W'(idx - hrde_pkg::KBD_KEY_BASE);
    bit_sel  = 3'd0;
    kind_d   = hrde_pkg::EV_TICK;
    code_d   = 8'd0;
    dx_d     = 8'd0;
    dy_d     = 8'd0;
    scroll_d = 8'd0;
    unique case (job_q.op)
      hrde_pkg::OP_MOUSE: begin
        if (idx == hrde_pkg::MOUSE_MOVE_BIT) begin
          kind_d = hrde_pkg::EV_MOVE;
          dx_d   = job_q.dx;
          dy_d   = job_q.dy;
        end else if (idx == hrde_pkg::MOUSE_SCROLL_BIT) begin
          kind_d   = hrde_pkg::EV_SCROLL;
          scroll_d = job_q.wheel;
        end else begin
          bit_sel = btn_idx[2:0];
          kind_d  = job_q.flags[bit_sel] ? hrde_pkg::EV_BTN_PRESS
                                         : hrde_pkg::EV_BTN_RELEASE;
          code_d  = {5'd0, bit_sel} + 8'd1;
        end
      end
      hrde_pkg::OP_KBD: begin
        if (idx < hrde_pkg::KBD_KEY_BASE) begin
          bit_sel = idx[2:0];
          kind_d  = job_q.flags[bit_sel] ? hrde_pkg::EV_KEY_PRESS
                                         : hrde_pkg::EV_KEY_RELEASE;
          code_d  = hrde_pkg::MOD_KEY_BASE | {5'd0, bit_sel};
        end else begin
          kind_d = (key_idx < hrde_pkg::KIDX_W'(hrde_pkg::NUM_SLOTS))
                   ? hrde_pkg::EV_KEY_RELEASE : hrde_pkg::EV_KEY_PRESS;
          code_d = job_q.keys[key_idx];
        end
      end
      default: begin
        kind_d = hrde_pkg::EV_TICK;
      end
    endcase
  end

  // Load the next job, retire events
  always_comb begin
    job_d        = job_q;
    mask_d       = mask_q;
    work_valid_d = work_valid_q;
    if (emit) begin
      mask_d = mask_rest;
      if (fin) work_valid_d = 1'b0;
    end
    if (pop_o) begin
      job_d        = job_i;
      mask_d       = job_i.mask;
      work_valid_d = 1'b1;
    end
    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold job and output payloads
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    mask_q <= mask_d;
    if (emit) begin
      kind_q   <= kind_d;
      time_q   <= job_q.stamp;
      code_q   <= code_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      scroll_q <= scroll_d;
      last_q   <= fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign event_time_o = time_q;
  assign code_o       = code_q;
  assign dx_o         = dx_q;
  assign dy_o         = dy_q;
  assign scroll_o     = scroll_q;
  assign last_o       = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q |-> (mask_q != '0))
    else $error("active job with no pending events");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !fin) |=> work_valid_q)
    else $error("job dropped before its last event");

endmodule

// ===== design/hid_report_diff_to_events.sv =====
// Top level of the HID report differencer: front end, job queue, event sequencer.
// Depends on hrde_pkg, hrde_front, hrde_queue and hrde_back.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  op, timestamp, flag bits, six key slots,
//                                                move x/y, wheel
//   out      output     out_valid_o / out_stall_i  event kind, time, code, dx, dy,
//                                                scroll, last
//
// The front end takes one item per cycle while the two-entry job queue has room.
// The sequencer emits one event per cycle while the output is not stalled; an item
// yields up to 20 events (a keyboard report), and its first event passes through
// the queue entry, the sequencer's job register and the output register. Items that
// cause no event (connect, unchanged reports) only update state.
// Reset clears the stored reports and empties the queue and output register.
// Output stall holds the current event; input stall is raised only while the queue is full.
module hid_report_diff_to_events (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [63:0]       timestamp_i,
  input  logic [7:0]        flag_bits_i,
  input  logic [7:0]        key_slot_0_i,
  input  logic [7:0]        key_slot_1_i,
  input  logic [7:0]        key_slot_2_i,
  input  logic [7:0]        key_slot_3_i,
  input  logic [7:0]        key_slot_4_i,
  input  logic [7:0]        key_slot_5_i,
  input  logic signed [7:0] move_x_i,
  input  logic signed [7:0] move_y_i,
  input  logic signed [7:0] wheel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_kind_o,
  output logic [63:0]       event_time_o,
  output logic [7:0]        code_o,
  output logic signed [7:0] out_dx_o,
  output logic signed [7:0] out_dy_o,
  output logic signed [7:0] out_scroll_o,
  output logic              last_o
);

  hrde_pkg::job_t push_job, head_job;
  logic           push, pop, q_full, q_empty;
  logic [7:0]     dx_raw, dy_raw, scroll_raw;

  // Classify items and track stored reports
  hrde_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .full_i  (q_full),
    .op_i    (hrde_pkg::op_e'(op_i)),
    .stamp_i (timestamp_i),
    .flags_i (flag_bits_i),
    .keys_i  ({key_slot_5_i, key_slot_4_i, key_slot_3_i,
               key_slot_2_i, key_slot_1_i, key_slot_0_i}),
    .dx_i    (8'(move_x_i)),
    .dy_i    (8'(move_y_i)),
    .wheel_i (8'(wheel_i)),
    .stall_o (in_stall_o),
    .push_o  (push),
    .job_o   (push_job)
  );

  // Decouple front and back
  hrde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Emit events one per cycle while the output is not stalled
  hrde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .event_kind_o (event_kind_o),
    .event_time_o (event_time_o),
    .code_o       (code_o),
    .dx_o         (dx_raw),
    .dy_o         (dy_raw),
    .scroll_o     (scroll_raw),
    .last_o       (last_o)
  );

  assign out_dx_o     = $signed(dx_raw);
  assign out_dy_o     = $signed(dy_raw);
  assign out_scroll_o = $signed(scroll_raw);

endmodule
